// ===== rtl/core/gcad_pkg.sv =====
// Shared constants, register codes and configuration types for the gyro calibration block.
package gcad_pkg;

    // Configuration register geometry
    localparam int CFG_W    = 16;
    localparam int ADDR_W   = 4;
    localparam int PDATA_W  = 32;

    // Training counter and divisor widths (divisor may reach 65536)
    localparam int CNT_W    = 16;
    localparam int DIV_W    = CNT_W + 1;

    // Register reset values
    localparam logic [CFG_W-1:0] CALIB_RST   = 16'd500;
    localparam logic [CFG_W-1:0] LMARGIN_RST = 16'd105;
    localparam logic [CFG_W-1:0] JMARGIN_RST = 16'd236;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_CALIB   = 2'd0,
        REG_LMARGIN = 2'd1,
        REG_JMARGIN = 2'd2
    } t_reg_idx;

    // Configuration seen by the back end
    typedef struct packed {
        logic [CFG_W-1:0] calib_count;
        logic [CFG_W-1:0] level_margin;
        logic [CFG_W-1:0] jump_margin;
    } t_cfg;

endpackage

// ===== rtl/core/gyro_calibrate_and_anomaly_detect.sv =====
// An accepted sample passes through the front-to-back queue and the result queue
// before it shows on the result ports. Throughput: one sample per cycle while the
// result queue has room; the last training sample starts a divide in the per-axis
// dividers, and later samples wait in the front-to-back queue until it finishes.
// Reset (synchronous, i_rst_n low): registers to defaults, statistics, previous
// sample and training count to zero, all queues emptied.
module gyro_calibrate_and_anomaly_detect #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample channel
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_x,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_y,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_z,
    // Result channel
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_training,
    output logic [2:0]                     o_above_flags,
    output logic [2:0]                     o_below_flags,
    output logic [2:0]                     o_jump_flags,
    output logic [SAMPLE_BITS-1:0]         o_jump_x,
    output logic [SAMPLE_BITS-1:0]         o_jump_y,
    output logic [SAMPLE_BITS-1:0]         o_jump_z,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcad_pkg::ADDR_W-1:0]    paddr,
    input  logic [gcad_pkg::PDATA_W-1:0]   pwdata,
    output logic [gcad_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int MID_W = 6 * SB;
    localparam int OUT_W = 10 + 3 * SB;

    gcad_pkg::t_cfg              r_cfg;
    gcad_pkg::t_reg_idx          reg_idx;
    logic                        cfg_wr;

    logic signed [SB-1:0]        in_sample  [3];
    logic        [SB-1:0]        in_jump    [3];
    logic signed [SB-1:0]        mid_sample [3];
    logic        [SB-1:0]        mid_jump   [3];
    logic                        in_take;
    logic [MID_W-1:0]            mid_wdata;
    logic [MID_W-1:0]            mid_rdata;
    logic                        mid_empty;
    logic                        mid_pop;
    logic                        out_full;
    logic                        out_push;
    logic                        bk_training;
    logic [2:0]                  bk_above;
    logic [2:0]                  bk_below;
    logic [2:0]                  bk_jflags;
    logic [OUT_W-1:0]            out_wdata;
    logic [OUT_W-1:0]            out_rdata;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = gcad_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calib_count  <= gcad_pkg::CALIB_RST;
            r_cfg.level_margin <= gcad_pkg::LMARGIN_RST;
            r_cfg.jump_margin  <= gcad_pkg::JMARGIN_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                gcad_pkg::REG_CALIB:   r_cfg.calib_count  <= pwdata[gcad_pkg::CFG_W-1:0];
                gcad_pkg::REG_LMARGIN: r_cfg.level_margin <= pwdata[gcad_pkg::CFG_W-1:0];
                gcad_pkg::REG_JMARGIN: r_cfg.jump_margin  <= pwdata[gcad_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            gcad_pkg::REG_CALIB:   prdata = gcad_pkg::PDATA_W'(r_cfg.calib_count);
            gcad_pkg::REG_LMARGIN: prdata = gcad_pkg::PDATA_W'(r_cfg.level_margin);
            gcad_pkg::REG_JMARGIN: prdata = gcad_pkg::PDATA_W'(r_cfg.jump_margin);
            default:               prdata = '0;
        endcase
    end

    // Front end
    assign in_take      = push && !full;
    assign in_sample[0] = i_sample_x;
    assign in_sample[1] = i_sample_y;
    assign in_sample[2] = i_sample_z;

    gcad_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (in_take),
        .i_sample (in_sample),
        .o_jump   (in_jump)
    );

    assign mid_wdata = {in_sample[0], in_sample[1], in_sample[2],
                        in_jump[0], in_jump[1], in_jump[2]};

    // Queue between front and back
    gcad_queue #(
        .WIDTH (MID_W),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (mid_wdata),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_rdata),
        .o_empty (mid_empty)
    );

    assign mid_sample[0] = mid_rdata[6*SB-1:5*SB];
    assign mid_sample[1] = mid_rdata[5*SB-1:4*SB];
    assign mid_sample[2] = mid_rdata[4*SB-1:3*SB];
    assign mid_jump[0]   = mid_rdata[3*SB-1:2*SB];
    assign mid_jump[1]   = mid_rdata[2*SB-1:SB];
    assign mid_jump[2]   = mid_rdata[SB-1:0];

    // Back end
    gcad_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_empty (mid_empty),
        .o_in_pop   (mid_pop),
        .i_sample   (mid_sample),
        .i_jump     (mid_jump),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_training (bk_training),
        .o_above    (bk_above),
        .o_below    (bk_below),
        .o_jflags   (bk_jflags)
    );

    assign out_wdata = {bk_training, bk_above, bk_below, bk_jflags,
                        mid_jump[0], mid_jump[1], mid_jump[2]};

    // Result queue
    gcad_queue #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wdata),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_empty (empty)
    );

    assign o_training    = out_rdata[OUT_W-1];
    assign o_above_flags = out_rdata[OUT_W-2:OUT_W-4];
    assign o_below_flags = out_rdata[OUT_W-5:OUT_W-7];
    assign o_jump_flags  = out_rdata[OUT_W-8:OUT_W-10];
    assign o_jump_x      = out_rdata[3*SB-1:2*SB];
    assign o_jump_y      = out_rdata[2*SB-1:SB];
    assign o_jump_z      = out_rdata[SB-1:0];

endmodule

// ===== rtl/core/gcad_queue.sv =====
// Small synchronous queue between pipeline sections.
module gcad_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/gcad_front.sv =====
// Front end: holds the previous sample and computes per-axis absolute jumps.
module gcad_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic signed [SAMPLE_BITS-1:0] i_sample [3],
    output logic        [SAMPLE_BITS-1:0] o_jump   [3]
);

    logic signed [SAMPLE_BITS-1:0] r_prev [3];
    logic signed [SAMPLE_BITS:0]   diff   [3];

    // |sample - previous|, always fits in SAMPLE_BITS unsigned
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a]   = (SAMPLE_BITS+1)'(i_sample[a]) - (SAMPLE_BITS+1)'(r_prev[a]);
            o_jump[a] = diff[a][SAMPLE_BITS] ? SAMPLE_BITS'(-diff[a])
                                             : diff[a][SAMPLE_BITS-1:0];
        end
    end

    // Previous sample follows every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= '0;
            end
        end else if (i_take) begin
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= i_sample[a];
            end
        end
    end

endmodule

// ===== rtl/core/gcad_back.sv =====
// Back end: training statistics, average-jump divider and anomaly flags.
module gcad_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gcad_pkg::t_cfg                i_cfg,
    input  logic                          i_in_empty,
    output logic                          o_in_pop,
    input  logic signed [SAMPLE_BITS-1:0] i_sample [3],
    input  logic        [SAMPLE_BITS-1:0] i_jump   [3],
    input  logic                          i_out_full,
    output logic                          o_out_push,
    output logic                          o_training,
    output logic [2:0]                    o_above,
    output logic [2:0]                    o_below,
    output logic [2:0]                    o_jflags
);

    localparam int SB = SAMPLE_BITS;
    localparam int JW = SAMPLE_BITS + gcad_pkg::CNT_W;
    localparam int SW = $clog2(JW + 1);
    localparam int CW = ((SAMPLE_BITS > gcad_pkg::CFG_W) ? SAMPLE_BITS : gcad_pkg::CFG_W) + 2;
    localparam int DW = gcad_pkg::DIV_W;

    typedef enum logic {
        S_RUN,
        S_DIV
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_mon, n_mon;
    logic [gcad_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [DW-1:0]                  r_div, n_div;
    logic [SW-1:0]                  r_step, n_step;
    logic signed [SB-1:0]           r_max [3], n_max [3];
    logic signed [SB-1:0]           r_min [3], n_min [3];
    // Jump sum; after the divide it holds the quotient (average in low bits)
    logic [JW-1:0]                  r_sum [3], n_sum [3];
    logic [DW-1:0]                  r_rem [3], n_rem [3];

    logic                           take;
    logic [gcad_pkg::CNT_W-1:0]     cnt_inc;
    logic [gcad_pkg::CNT_W-1:0]     target;
    logic                           train_done;
    logic [DW:0]                    trial [3];
    logic                           qbit  [3];
    logic signed [CW-1:0]           s_e   [3];
    logic signed [CW-1:0]           hi_lim[3];
    logic signed [CW-1:0]           lo_lim[3];
    logic [CW-1:0]                  j_e   [3];
    logic [CW-1:0]                  j_lim [3];

    assign take       = (r_state == S_RUN) && !i_in_empty && !i_out_full;
    assign o_in_pop   = take;
    assign o_out_push = take;
    assign o_training = !r_mon;

    // Training end test; zero count behaves as one, counter wrap ends training
    assign cnt_inc    = r_cnt + gcad_pkg::CNT_W'(1);
    assign target     = (i_cfg.calib_count == '0) ? gcad_pkg::CNT_W'(1) : i_cfg.calib_count;
    assign train_done = (cnt_inc >= target) || (cnt_inc == '0);

    // Limit compares, wide enough to never overflow
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s_e[a]    = CW'(i_sample[a]);
            hi_lim[a] = CW'(r_max[a]) + CW'($signed({1'b0, i_cfg.level_margin}));
            lo_lim[a] = CW'(r_min[a]) - CW'($signed({1'b0, i_cfg.level_margin}));
            j_e[a]    = CW'(i_jump[a]);
            j_lim[a]  = CW'(r_sum[a][SB-1:0]) + CW'(i_cfg.jump_margin);
            o_above[a]  = r_mon && (s_e[a] > hi_lim[a]);
            o_below[a]  = r_mon && (s_e[a] < lo_lim[a]);
            o_jflags[a] = r_mon && (j_e[a] > j_lim[a]);
        end
    end

    // Restoring divide step, one quotient bit per cycle on each axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            trial[a] = {r_rem[a], r_sum[a][JW-1]};
            qbit[a]  = (trial[a] >= {1'b0, r_div});
        end
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_mon   = r_mon;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_step  = r_step;
        for (int a = 0; a < 3; a++) begin
            n_max[a] = r_max[a];
            n_min[a] = r_min[a];
            n_sum[a] = r_sum[a];
            n_rem[a] = r_rem[a];
        end
        case (r_state)
            S_RUN: begin
                if (take && !r_mon) begin
                    for (int a = 0; a < 3; a++) begin
                        if (i_sample[a] > r_max[a]) begin
                            n_max[a] = i_sample[a];
                        end
                        if (i_sample[a] < r_min[a]) begin
                            n_min[a] = i_sample[a];
                        end
                        n_sum[a] = r_sum[a] + JW'(i_jump[a]);
                        n_rem[a] = '0;
                    end
                    n_cnt = cnt_inc;
                    if (train_done) begin
                        n_state = S_DIV;
                        n_div   = (cnt_inc == '0) ? {1'b1, {gcad_pkg::CNT_W{1'b0}}}
                                                  : {1'b0, cnt_inc};
                        n_step  = SW'(JW);
                    end
                end
            end
            S_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    n_rem[a] = qbit[a] ? DW'(trial[a] - {1'b0, r_div}) : trial[a][DW-1:0];
                    n_sum[a] = {r_sum[a][JW-2:0], qbit[a]};
                end
                n_step = r_step - SW'(1);
                if (r_step == SW'(1)) begin
                    n_state = S_RUN;
                    n_mon   = 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // State and trained statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_mon   <= 1'b0;
            r_cnt   <= '0;
            for (int a = 0; a < 3; a++) begin
                r_max[a] <= '0;
                r_min[a] <= '0;
                r_sum[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_mon   <= n_mon;
            r_cnt   <= n_cnt;
            for (int a = 0; a < 3; a++) begin
                r_max[a] <= n_max[a];
                r_min[a] <= n_min[a];
                r_sum[a] <= n_sum[a];
            end
        end
    end

    // Divider working registers
    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_step <= n_step;
        for (int a = 0; a < 3; a++) begin
            r_rem[a] <= n_rem[a];
        end
    end

`ifndef SYNTHESIS
    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_in_pop)
        else $error("beat taken while divider busy");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == SW'(1)) |=> (r_state == S_RUN && r_mon))
        else $error("divide did not finish into monitoring");

    a_mon_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mon |=> (r_mon && $stable(r_cnt)))
        else $error("training state changed while monitoring");

    a_train_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_training) |-> ((o_above | o_below | o_jflags) == 3'b000))
        else $error("flag raised on a training beat");
`endif

endmodule

// ===== test/gyro_calibrate_and_anomaly_detect_tb.sv =====
// Self-checking testbench for the gyro calibration and anomaly detection block.
`timescale 1ns / 1ps

module gyro_calibrate_and_anomaly_detect_tb;

    localparam int     SAMPLE_W    = 16;
    localparam int     SUM_W       = SAMPLE_W + 16;
    localparam longint SAMPLE_TOP  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_BOT  = -SAMPLE_TOP - 1;
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     TRAIN_ITEMS = 30;
    localparam int     PHASE_ITEMS = 270;
    localparam int     HOLD_LEN    = 400;
    localparam int     SETTLE_CYC  = 40;

    typedef logic [2:0][SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic                       training;
        logic [2:0]                 above;
        logic [2:0]                 below;
        logic [2:0]                 jflags;
        logic [2:0][SAMPLE_W-1:0]   jump;
    } t_gyro_result;

    typedef enum int {PROBE_HI, PROBE_LO, PROBE_JUMP} t_probe;

    // Predicts one result per sample and checks result beats in order
    class t_gyro_scoreboard;
        logic [gcad_pkg::CFG_W-1:0] calib_count;
        logic [gcad_pkg::CFG_W-1:0] level_margin;
        logic [gcad_pkg::CFG_W-1:0] jump_margin;
        logic [gcad_pkg::CNT_W-1:0] train_count;
        bit                         monitoring;
        logic signed [SAMPLE_W-1:0] last_sample [3];
        logic signed [SAMPLE_W-1:0] trained_max [3];
        logic signed [SAMPLE_W-1:0] trained_min [3];
        logic [SUM_W-1:0]           jump_total  [3];
        logic [SAMPLE_W-1:0]        avg_jump    [3];
        t_gyro_result               expected_results [$];
        int errors, n_samples, n_training, n_above, n_below, n_jump;

        function new();
            calib_count  = gcad_pkg::CALIB_RST;
            level_margin = gcad_pkg::LMARGIN_RST;
            jump_margin  = gcad_pkg::JMARGIN_RST;
            train_count  = '0;
            monitoring   = 1'b0;
            for (int a = 0; a < 3; a++) begin
                last_sample[a] = '0;
                trained_max[a] = '0;
                trained_min[a] = '0;
                jump_total[a]  = '0;
                avg_jump[a]    = '0;
            end
            errors = 0;
            n_samples = 0;
            n_training = 0;
            n_above = 0;
            n_below = 0;
            n_jump = 0;
        endfunction

        function void write_reg(gcad_pkg::t_reg_idx idx, logic [gcad_pkg::CFG_W-1:0] value);
            case (idx)
                gcad_pkg::REG_CALIB:   calib_count  = value;
                gcad_pkg::REG_LMARGIN: level_margin = value;
                gcad_pkg::REG_JMARGIN: jump_margin  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Accepted sample: advance the model and queue the expected beat
        function void note_sample(t_sample s);
            t_gyro_result               r;
            longint                     v, d;
            logic [gcad_pkg::CNT_W-1:0] target;
            logic [gcad_pkg::DIV_W-1:0] divisor;
            r = '0;
            r.training = !monitoring;
            for (int a = 0; a < 3; a++) begin
                v = longint'($signed(s[a]));
                d = v - longint'(last_sample[a]);
                if (d < 0) d = -d;
                r.jump[a] = d[SAMPLE_W-1:0];
            end
            if (!monitoring) begin
                for (int a = 0; a < 3; a++) begin
                    if ($signed(s[a]) > trained_max[a]) trained_max[a] = s[a];
                    if ($signed(s[a]) < trained_min[a]) trained_min[a] = s[a];
                    jump_total[a] = jump_total[a] + SUM_W'(r.jump[a]);
                end
                train_count = train_count + gcad_pkg::CNT_W'(1);
                // zero count behaves as one
                target = (calib_count == '0) ? gcad_pkg::CNT_W'(1) : calib_count;
                if (train_count >= target || train_count == '0) begin
                    divisor = (train_count == '0) ?
                              (gcad_pkg::DIV_W'(1) << gcad_pkg::CNT_W) :
                              gcad_pkg::DIV_W'(train_count);
                    for (int a = 0; a < 3; a++)
                        avg_jump[a] = SAMPLE_W'(jump_total[a] / SUM_W'(divisor));
                    monitoring = 1'b1;
                end
            end else begin
                for (int a = 0; a < 3; a++) begin
                    v = longint'($signed(s[a]));
                    if (v > longint'(trained_max[a]) + longint'(level_margin))
                        r.above[a] = 1'b1;
                    if (v < longint'(trained_min[a]) - longint'(level_margin))
                        r.below[a] = 1'b1;
                    if (longint'(r.jump[a]) > longint'(avg_jump[a]) + longint'(jump_margin))
                        r.jflags[a] = 1'b1;
                end
            end
            for (int a = 0; a < 3; a++)
                last_sample[a] = s[a];
            n_samples++;
            if (r.training) n_training++;
            if (r.above != '0) n_above++;
            if (r.below != '0) n_below++;
            if (r.jflags != '0) n_jump++;
            expected_results.push_back(r);
        endfunction

        function void report(string what, longint want, longint got);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        // Result beat: compare field by field with the oldest expectation
        function void check_result(t_gyro_result got);
            t_gyro_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat with nothing expected: %h", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.training !== want.training)
                report("training", longint'(want.training), longint'(got.training));
            if (got.above !== want.above)
                report("above_flags", longint'(want.above), longint'(got.above));
            if (got.below !== want.below)
                report("below_flags", longint'(want.below), longint'(got.below));
            if (got.jflags !== want.jflags)
                report("jump_flags", longint'(want.jflags), longint'(got.jflags));
            for (int a = 0; a < 3; a++)
                if (got.jump[a] !== want.jump[a])
                    report($sformatf("jump axis %0d", a), longint'(want.jump[a]),
                           longint'(got.jump[a]));
        endfunction
    endclass

    // Block ports
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [SAMPLE_W-1:0]            i_sample_x = '0;
    logic [SAMPLE_W-1:0]            i_sample_y = '0;
    logic [SAMPLE_W-1:0]            i_sample_z = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           o_training;
    logic [2:0]                     o_above_flags;
    logic [2:0]                     o_below_flags;
    logic [2:0]                     o_jump_flags;
    logic [SAMPLE_W-1:0]            o_jump_x;
    logic [SAMPLE_W-1:0]            o_jump_y;
    logic [SAMPLE_W-1:0]            o_jump_z;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [gcad_pkg::ADDR_W-1:0]    paddr = '0;
    logic [gcad_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [gcad_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    t_gyro_scoreboard sb;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int hold_cycles = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    gyro_calibrate_and_anomaly_detect #(.SAMPLE_BITS(SAMPLE_W)) dut (.*);

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     sb.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int pick_gap(bit steady);
        return steady ? 0 : int'($urandom_range(10, 0));
    endfunction

    function automatic logic [SAMPLE_W-1:0] saturate_word(longint v);
        if (v > SAMPLE_TOP) v = SAMPLE_TOP;
        else if (v < SAMPLE_BOT) v = SAMPLE_BOT;
        return v[SAMPLE_W-1:0];
    endfunction

    // Training data: bounded random walk so the trained limits stay moderate
    function automatic logic [SAMPLE_W-1:0] train_axis(int a);
        longint v;
        v = longint'(sb.last_sample[a]) + longint'($urandom_range(800, 0)) - 400;
        if (v > 6000) v = 6000;
        if (v < -6000) v = -6000;
        return saturate_word(v);
    endfunction

    // Monitoring data: mostly near the trained band or a step near the jump
    // threshold, some full-range noise
    function automatic logic [SAMPLE_W-1:0] random_axis(int a);
        longint lo, hi, lim;
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 10)
            return SAMPLE_W'($urandom());
        if (pick < 45) begin
            lo = longint'(sb.trained_min[a]) - longint'(sb.level_margin) - 64;
            hi = longint'(sb.trained_max[a]) + longint'(sb.level_margin) + 64;
            return saturate_word(lo + longint'($urandom_range(32'(hi - lo), 0)));
        end
        lim = longint'(sb.avg_jump[a]) + longint'(sb.jump_margin) + 64;
        if (lim > 70000) lim = 70000;
        return saturate_word(longint'(sb.last_sample[a]) - lim +
                             longint'($urandom_range(32'(2 * lim), 0)));
    endfunction

    // Values right at, or one past, each trained threshold
    function automatic logic [SAMPLE_W-1:0] probe_value(t_probe kind, int a, longint extra);
        case (kind)
            PROBE_HI:
                return saturate_word(longint'(sb.trained_max[a]) +
                                     longint'(sb.level_margin) + extra);
            PROBE_LO:
                return saturate_word(longint'(sb.trained_min[a]) -
                                     longint'(sb.level_margin) - extra);
            default:
                return saturate_word(longint'(sb.last_sample[a]) + longint'(sb.avg_jump[a]) +
                                     longint'(sb.jump_margin) + extra);
        endcase
    endfunction

    // Input beat with a random lead-in gap; push stays up across back-to-back beats
    task automatic send_sample(input t_sample s);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_sample_x <= s[0];
        i_sample_y <= s[1];
        i_sample_z <= s[2];
        do @(posedge i_clk); while (full);
        sb.note_sample(s);
        if (sb.n_samples % 40 == 0) tx_steady = ($urandom_range(3, 0) == 0);
    endtask

    // Register write: setup phase, access phase held until pready, then an idle phase
    task automatic write_reg(input gcad_pkg::t_reg_idx idx,
                             input logic [gcad_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= gcad_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every result, then let the divider settle
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Result side
    initial begin : result_sink
        int gap;
        int beats;
        t_gyro_result got;
        beats = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = pick_gap(rx_steady);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got.training = o_training;
            got.above    = o_above_flags;
            got.below    = o_below_flags;
            got.jflags   = o_jump_flags;
            got.jump     = {o_jump_z, o_jump_y, o_jump_x};
            sb.check_result(got);
            beats++;
            if (beats % 40 == 0) rx_steady = ($urandom_range(3, 0) == 0);
        end
    end

    // Stimulus
    initial begin : stimulus
        t_sample s;
        int i, a, k, e, ph;
        longint extremes [5];
        extremes = '{SAMPLE_TOP, SAMPLE_BOT, SAMPLE_TOP, 0, -1};
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(gcad_pkg::REG_CALIB, gcad_pkg::CFG_W'(40));
        write_reg(gcad_pkg::REG_LMARGIN, gcad_pkg::CFG_W'(300));
        write_reg(gcad_pkg::REG_JMARGIN, gcad_pkg::CFG_W'(500));

        // Training, cut short by a zero count once samples are in
        for (i = 0; i < TRAIN_ITEMS; i++) begin
            for (a = 0; a < 3; a++) s[a] = train_axis(a);
            send_sample(s);
        end
        drain();
        write_reg(gcad_pkg::REG_CALIB, gcad_pkg::CFG_W'(0));
        for (a = 0; a < 3; a++) s[a] = train_axis(a);
        send_sample(s);

        // Threshold probes, then field extremes
        for (k = 0; k < 3; k++) begin
            for (e = 0; e < 2; e++) begin
                for (a = 0; a < 3; a++) s[a] = probe_value(t_probe'(k), a, longint'(e));
                send_sample(s);
            end
        end
        for (i = 0; i < 5; i++) begin
            for (a = 0; a < 3; a++) s[a] = saturate_word(extremes[i]);
            send_sample(s);
        end
        s = {saturate_word(0), saturate_word(SAMPLE_BOT), saturate_word(SAMPLE_TOP)};
        send_sample(s);

        // Random phases, each under its own register setting
        for (ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(gcad_pkg::REG_LMARGIN, gcad_pkg::CFG_W'(1));
                    write_reg(gcad_pkg::REG_JMARGIN, gcad_pkg::CFG_W'(1));
                end
                1: begin
                    // count has no effect once monitoring
                    write_reg(gcad_pkg::REG_CALIB, gcad_pkg::CFG_W'(65535));
                    write_reg(gcad_pkg::REG_LMARGIN, gcad_pkg::CFG_W'(65535));
                    write_reg(gcad_pkg::REG_JMARGIN, gcad_pkg::CFG_W'(65535));
                end
                2: begin
                    write_reg(gcad_pkg::REG_CALIB, gcad_pkg::CFG_W'(1));
                    write_reg(gcad_pkg::REG_LMARGIN,
                              gcad_pkg::CFG_W'($urandom_range(2000, 1)));
                    write_reg(gcad_pkg::REG_JMARGIN,
                              gcad_pkg::CFG_W'($urandom_range(2000, 1)));
                end
                3: begin
                    write_reg(gcad_pkg::REG_LMARGIN, gcad_pkg::LMARGIN_RST);
                    write_reg(gcad_pkg::REG_JMARGIN, gcad_pkg::JMARGIN_RST);
                    // receiver stalls while the sender keeps offering beats
                    hold_cycles = HOLD_LEN;
                end
                4: begin
                    write_reg(gcad_pkg::REG_LMARGIN,
                              gcad_pkg::CFG_W'($urandom_range(600, 1)));
                    write_reg(gcad_pkg::REG_JMARGIN,
                              gcad_pkg::CFG_W'($urandom_range(600, 1)));
                end
                default: begin
                    write_reg(gcad_pkg::REG_CALIB,
                              gcad_pkg::CFG_W'($urandom_range(65535, 0)));
                    write_reg(gcad_pkg::REG_LMARGIN,
                              gcad_pkg::CFG_W'($urandom_range(65535, 1)));
                    write_reg(gcad_pkg::REG_JMARGIN,
                              gcad_pkg::CFG_W'($urandom_range(3000, 1)));
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                for (a = 0; a < 3; a++) s[a] = random_axis(a);
                send_sample(s);
            end
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d samples (%0d while training) across %0d register writes.",
                 sb.n_samples, sb.n_training, reg_writes);
        $display("Results with above/below/jump flags: %0d/%0d/%0d; %0d mismatches.",
                 sb.n_above, sb.n_below, sb.n_jump, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
